@@ rtl/trig_function_unit_assert.svh @@
// assertion macros shared by the trig function unit
// expects clk and arst_n in the scope of use
`ifndef TRIG_FUNCTION_UNIT_ASSERT_SVH
`define TRIG_FUNCTION_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define TFU_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("trig unit: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define TFU_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("trig unit: implication failed");

`endif

@@ rtl/trig_pkg.sv @@
// shared types, constants and rounding helper for the trig function unit
// no dependencies
package trig_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;
	localparam int IFRAC     = 30;

	localparam int QDEPTH    = 4;
	localparam int MOD_STEPS = 5;
	localparam int SIN_LAT   = 15;
	localparam int DIV1_NW   = 63;
	localparam int DIV1_DW   = 33;
	localparam int DIV2_NW   = 61;
	localparam int DIV2_DW   = 63;

	// 2*pi at the input fraction width
	localparam logic [31:0] TAU_W = 32'd105414357;

	localparam logic signed [35:0] PI30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI30 = 36'sd1686629713;
	localparam logic signed [35:0] TAU30     = 36'sd6746518852;

	localparam logic signed [31:0] COEF [5] = '{
		32'sd1073741818, -32'sd178956863, 32'sd8947518, -32'sd212681, 32'sd2794
	};

	localparam logic [31:0] MAXW = 32'h7fff_ffff;
	localparam logic [31:0] MINW = 32'h8000_0000;

	typedef enum logic [2:0] {
		K_SIN = 3'd0,
		K_COS = 3'd1,
		K_TAN = 3'd2,
		K_SEC = 3'd3,
		K_CSC = 3'd4,
		K_COT = 3'd5
	} kind_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic        neg;
		logic [31:0] mag;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] kind;
	} tag_t;

	typedef struct packed {
		logic               vld;
		logic [2:0]         kind;
		logic               fixed;
		logic               sat;
		logic               qneg;
		logic [31:0]        fix_val;
		logic signed [63:0] q;
	} res_sb_t;

	// divide by 2^sh, round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
		input int unsigned sh);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = ((m >> (sh - 1)) + 64'd1) >> 1;
		return v[63] ? -$signed(m) : $signed(m);
	endfunction

endpackage

@@ rtl/trig_front.sv @@
// front end: takes input beats and splits the angle into sign and magnitude
// depends on trig_pkg
module trig_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // angle
	input  logic [2:0]           s_tuser,  // kind
	input  trig_pkg::q_stat_t    qstat,
	output logic                 push,
	output trig_pkg::item_t      item
);

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && !qstat.full;

	always_comb begin
		item.kind = s_tuser;
		item.neg  = s_tdata[31];
		item.mag  = s_tdata[31] ? 32'(-s_tdata) : s_tdata;
	end

endmodule

@@ rtl/trig_queue.sv @@
// small fifo between the front end and the compute pipeline
// depends on trig_pkg
module trig_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  trig_pkg::item_t   item_in,
	input  logic              pop,
	output trig_pkg::item_t   item_out,
	output trig_pkg::q_stat_t qstat
);

	localparam int PW = $clog2(trig_pkg::QDEPTH);

	trig_pkg::item_t fifo_q [trig_pkg::QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     count_q;

	assign qstat.full  = (count_q == (PW+1)'(trig_pkg::QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign item_out    = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/trig_sin_core.sv @@
// pipelined sine: fold into [-pi/2, pi/2], then odd ninth-degree polynomial by horner
// depends on trig_pkg
module trig_sin_core (
	input  logic               clk,
	input  logic               en,
	input  logic signed [35:0] x,
	output logic signed [33:0] y
);

	logic signed [35:0] f1_s, f2_s, f3_s;
	logic signed [63:0] xx_s;
	logic signed [31:0] xd_s  [10];
	logic signed [33:0] x2d_s [8];
	logic signed [67:0] p_s   [4];
	logic signed [33:0] acc_s [4];
	logic signed [65:0] pf_s;
	logic signed [33:0] y_s;
	logic signed [35:0] x1, x2f, x3;

	// three reflections
	always_comb begin
		x1  = ((trig_pkg::PI30 - x) < x) ? (trig_pkg::PI30 - x) : x;
		x2f = ((-trig_pkg::PI30 - f1_s) > f1_s) ? (-trig_pkg::PI30 - f1_s) : f1_s;
		x3  = ((trig_pkg::PI30 - f2_s) < f2_s) ? (trig_pkg::PI30 - f2_s) : f2_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s     <= x1;
			f2_s     <= x2f;
			f3_s     <= x3;
			xx_s     <= $signed(f3_s[31:0]) * $signed(f3_s[31:0]);
			xd_s[0]  <= f3_s[31:0];
			x2d_s[0] <= 34'(trig_pkg::rnd_shr(xx_s, trig_pkg::IFRAC));
			pf_s     <= xd_s[9] * acc_s[3];
			y_s      <= 34'(trig_pkg::rnd_shr(64'(pf_s), trig_pkg::IFRAC));
			for (int i = 1; i < 10; i++) begin
				xd_s[i] <= xd_s[i-1];
			end
			for (int i = 1; i < 8; i++) begin
				x2d_s[i] <= x2d_s[i-1];
			end
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_horner
		logic signed [33:0] acc_in;
		if (j == 0) begin : g_first
			assign acc_in = 34'(trig_pkg::COEF[4]);
		end else begin : g_next
			assign acc_in = acc_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[j]   <= acc_in * x2d_s[2*j];
				acc_s[j] <= 34'(trig_pkg::COEF[3-j])
					+ 34'(trig_pkg::rnd_shr(64'(p_s[j]), trig_pkg::IFRAC));
			end
		end
	end

	assign y = y_s;

endmodule

@@ rtl/trig_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// no dependencies; carries a sideband word alongside
module trig_div #(
	parameter int NW   = 63,
	parameter int DW   = 33,
	parameter int SB_W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [NW-1:0]   n,
	input  logic [DW-1:0]   d,
	input  logic [SB_W-1:0] sb_in,
	output logic [NW-1:0]   q,
	output logic [SB_W-1:0] sb_out
);

	logic [DW-1:0]   rem_s [NW];
	logic [DW-1:0]   den_s [NW];
	logic [NW-1:0]   num_s [NW];
	logic [NW-1:0]   quo_s [NW];
	logic [SB_W-1:0] sb_s  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0]   rem_p, den_p;
		logic [NW-1:0]   num_p, quo_p;
		logic [SB_W-1:0] sb_p;
		logic [DW:0]     rw, df;
		logic            ge;
		if (k == 0) begin : g_head
			assign rem_p = '0;
			assign den_p = d;
			assign num_p = n;
			assign quo_p = '0;
			assign sb_p  = sb_in;
		end else begin : g_body
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
			assign sb_p  = sb_s[k-1];
		end
		assign rw = {rem_p, num_p[NW-1]};
		assign df = rw - {1'b0, den_p};
		assign ge = (rw >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? df[DW-1:0] : rw[DW-1:0];
				den_s[k] <= den_p;
				num_s[k] <= num_p << 1;
				quo_s[k] <= {quo_p[NW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sb_s[k] <= '0;
			end else if (en) begin
				sb_s[k] <= sb_p;
			end
		end
	end

	assign q      = quo_s[NW-1];
	assign sb_out = sb_s[NW-1];

endmodule

@@ rtl/trig_back.sv @@
// compute pipeline: range reduction, sine cores, two dividers, rounding
// depends on trig_pkg, trig_sin_core, trig_div
module trig_back (
	input  logic              clk,
	input  logic              arst_n,
	input  trig_pkg::item_t   item,
	input  trig_pkg::q_stat_t qstat,
	output logic              pop,
	output logic              out_vld,
	input  logic              out_rdy,
	output logic [31:0]       out_value,
	output logic              out_sat
);

	localparam int SBW = $bits(trig_pkg::res_sb_t);
	localparam int MS  = trig_pkg::MOD_STEPS;

	logic adv;
	assign adv = !out_vld || out_rdy;
	assign pop = adv && !qstat.empty;

	// angle mod 2*pi, magnitude only, one quotient bit per stage
	trig_pkg::tag_t mtag_s [MS];
	logic           mneg_s [MS];
	logic [31:0]    mrem_s [MS];

	for (genvar k = 0; k < MS; k++) begin : g_mod
		localparam logic [31:0] TK = trig_pkg::TAU_W << (MS - 1 - k);
		trig_pkg::tag_t tag_p;
		logic           neg_p;
		logic [31:0]    rem_p;
		if (k == 0) begin : g_head
			assign tag_p = '{vld: pop, kind: item.kind};
			assign neg_p = item.neg;
			assign rem_p = item.mag;
		end else begin : g_body
			assign tag_p = mtag_s[k-1];
			assign neg_p = mneg_s[k-1];
			assign rem_p = mrem_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				mneg_s[k] <= neg_p;
				mrem_s[k] <= (rem_p >= TK) ? rem_p - TK : rem_p;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mtag_s[k] <= '0;
			end else if (adv) begin
				mtag_s[k] <= tag_p;
			end
		end
	end

	trig_pkg::tag_t     tag_p1, tag_p2, tag_p3;
	logic signed [35:0] r30_p1, xs_p2, xc_p2, xs_p3, xc_p3;
	logic signed [35:0] mag30;
	assign mag30 = $signed({3'b000, mrem_s[MS-1][26:0], 6'b000000});

	always_ff @(posedge clk) begin
		if (adv) begin
			r30_p1 <= mneg_s[MS-1] ? -mag30 : mag30;
			xs_p2  <= r30_p1;
			xc_p2  <= trig_pkg::HALF_PI30 - r30_p1;
			xs_p3  <= xs_p2;
			xc_p3  <= (xc_p2 >= trig_pkg::TAU30) ? xc_p2 - trig_pkg::TAU30 : xc_p2;
		end
	end

	trig_pkg::tag_t sd_s [trig_pkg::SIN_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_p1 <= '0;
			tag_p2 <= '0;
			tag_p3 <= '0;
			for (int i = 0; i < trig_pkg::SIN_LAT; i++) begin
				sd_s[i] <= '0;
			end
		end else if (adv) begin
			tag_p1  <= mtag_s[MS-1];
			tag_p2  <= tag_p1;
			tag_p3  <= tag_p2;
			sd_s[0] <= tag_p3;
			for (int i = 1; i < trig_pkg::SIN_LAT; i++) begin
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	logic signed [33:0] s_y, c_y;

	trig_sin_core u_sin_s (.clk(clk), .en(adv), .x(xs_p3), .y(s_y));
	trig_sin_core u_sin_c (.clk(clk), .en(adv), .x(xc_p3), .y(c_y));

	// operand select for the first division
	logic [33:0]       s_abs, c_abs;
	logic [32:0]       num_c, den_c;
	logic              num_neg, den_neg;
	trig_pkg::res_sb_t sb_dc;

	always_comb begin
		s_abs   = s_y[33] ? 34'(-s_y) : 34'(s_y);
		c_abs   = c_y[33] ? 34'(-c_y) : 34'(c_y);
		num_c   = s_abs[32:0];
		num_neg = s_y[33];
		den_c   = c_abs[32:0];
		den_neg = c_y[33];
		sb_dc   = '0;
		sb_dc.vld  = sd_s[trig_pkg::SIN_LAT-1].vld;
		sb_dc.kind = sd_s[trig_pkg::SIN_LAT-1].kind;
		case (sd_s[trig_pkg::SIN_LAT-1].kind)
			trig_pkg::K_SIN: sb_dc.q = 64'(s_y);
			trig_pkg::K_COS: sb_dc.q = 64'(c_y);
			trig_pkg::K_TAN: begin
				if (c_y == '0) begin
					sb_dc.fixed   = 1'b1;
					sb_dc.sat     = 1'b1;
					sb_dc.fix_val = s_y[33] ? trig_pkg::MINW : trig_pkg::MAXW;
				end
			end
			trig_pkg::K_SEC: begin
				num_c   = 33'd1 << trig_pkg::IFRAC;
				num_neg = 1'b0;
				if (c_y == '0) begin
					sb_dc.fixed   = 1'b1;
					sb_dc.sat     = 1'b1;
					sb_dc.fix_val = trig_pkg::MAXW;
				end
			end
			trig_pkg::K_CSC: begin
				num_c   = 33'd1 << trig_pkg::IFRAC;
				num_neg = 1'b0;
				den_c   = s_abs[32:0];
				den_neg = s_y[33];
				if (s_y == '0) begin
					sb_dc.fixed   = 1'b1;
					sb_dc.sat     = 1'b1;
					sb_dc.fix_val = trig_pkg::MAXW;
				end
			end
			trig_pkg::K_COT: begin
				// infinite tangent gives zero
				if (c_y == '0) begin
					sb_dc.fixed = 1'b1;
					sb_dc.sat   = 1'b1;
				end
			end
			default: sb_dc.fixed = 1'b1;
		endcase
		sb_dc.qneg = num_neg ^ den_neg;
	end

	logic [32:0]       num1_d, den1_d;
	trig_pkg::res_sb_t sb1_d;

	always_ff @(posedge clk) begin
		if (adv) begin
			num1_d <= num_c;
			den1_d <= den_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb1_d <= '0;
		end else if (adv) begin
			sb1_d <= sb_dc;
		end
	end

	logic [trig_pkg::DIV1_NW-1:0] q1;
	logic [SBW-1:0]               sb1_ov;

	trig_div #(
		.NW(trig_pkg::DIV1_NW), .DW(trig_pkg::DIV1_DW), .SB_W(SBW)
	) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.n({num1_d, 30'd0}), .d(den1_d), .sb_in(sb1_d),
		.q(q1), .sb_out(sb1_ov)
	);

	// quotient sign and cot's second operand
	trig_pkg::res_sb_t sb1_o, sb_ec;
	logic signed [63:0] t_c;
	logic [63:0]        t_abs;

	always_comb begin
		sb1_o = trig_pkg::res_sb_t'(sb1_ov);
		t_c   = sb1_o.qneg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
		t_abs = t_c[63] ? 64'(-t_c) : 64'(t_c);
		sb_ec = sb1_o;
		case (sb1_o.kind)
			trig_pkg::K_TAN, trig_pkg::K_SEC, trig_pkg::K_CSC: sb_ec.q = t_c;
			trig_pkg::K_COT: begin
				sb_ec.qneg = t_c[63];
				if (!sb1_o.fixed && t_c == '0) begin
					sb_ec.fixed   = 1'b1;
					sb_ec.sat     = 1'b1;
					sb_ec.fix_val = trig_pkg::MAXW;
				end
			end
			default: sb_ec.q = sb1_o.q;
		endcase
	end

	logic [trig_pkg::DIV2_DW-1:0] den2_e;
	trig_pkg::res_sb_t            sb2_e;

	always_ff @(posedge clk) begin
		if (adv) begin
			den2_e <= t_abs[trig_pkg::DIV2_DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb2_e <= '0;
		end else if (adv) begin
			sb2_e <= sb_ec;
		end
	end

	logic [trig_pkg::DIV2_NW-1:0] q2;
	logic [SBW-1:0]               sb2_ov;

	trig_div #(
		.NW(trig_pkg::DIV2_NW), .DW(trig_pkg::DIV2_DW), .SB_W(SBW)
	) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.n({1'b1, 60'd0}), .d(den2_e), .sb_in(sb2_e),
		.q(q2), .sb_out(sb2_ov)
	);

	trig_pkg::res_sb_t  sb2_o, sb_g;
	logic signed [63:0] qf, v_g;

	always_comb begin
		sb2_o = trig_pkg::res_sb_t'(sb2_ov);
		if (sb2_o.kind == trig_pkg::K_COT) begin
			qf = sb2_o.qneg ? -$signed({3'b000, q2}) : $signed({3'b000, q2});
		end else begin
			qf = sb2_o.q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_g <= trig_pkg::rnd_shr(qf, trig_pkg::IFRAC - trig_pkg::FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_g <= '0;
		end else if (adv) begin
			sb_g <= sb2_o;
		end
	end

	// output register with clamp
	logic [31:0] value_q;
	logic        sat_q, vld_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sb_g.fixed) begin
				value_q <= sb_g.fix_val;
				sat_q   <= sb_g.sat;
			end else if (v_g > $signed(64'(trig_pkg::MAXW))) begin
				value_q <= trig_pkg::MAXW;
				sat_q   <= 1'b1;
			end else if (v_g < -$signed(64'(trig_pkg::MINW))) begin
				value_q <= trig_pkg::MINW;
				sat_q   <= 1'b1;
			end else begin
				value_q <= v_g[31:0];
				sat_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= sb_g.vld;
		end
	end

	assign out_vld   = vld_q;
	assign out_value = value_q;
	assign out_sat   = sat_q;

endmodule

@@ rtl/trig_function_unit.sv @@
// fixed-point sin/cos/tan/sec/csc/cot, q8.24 in and out
// throughput one beat per cycle while the output is not stalled;
// the two 61- and 63-stage dividers set the depth
// a stalled output holds the whole compute pipe, a 4-deep fifo absorbs input
// arst_n clears all valid and pointer state; no configuration
module trig_function_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // angle
	input  logic [2:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // value
	output logic [0:0]  m_tuser   // saturated
);

	`include "trig_function_unit_assert.svh"

	trig_pkg::q_stat_t qstat;
	trig_pkg::item_t   item_in, item_out;
	logic              push, pop;
	logic [31:0]       value;
	logic              sat;
	logic              sat_val_ok;

	trig_front u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .qstat(qstat), .push(push), .item(item_in)
	);

	trig_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .item_in(item_in),
		.pop(pop), .item_out(item_out), .qstat(qstat)
	);

	trig_back u_back (
		.clk(clk), .arst_n(arst_n), .item(item_out), .qstat(qstat),
		.pop(pop), .out_vld(m_tvalid), .out_rdy(m_tready),
		.out_value(value), .out_sat(sat)
	);

	assign m_tdata = value;
	assign m_tuser = sat;

	// a saturated result sits at one end of the range or at zero
	assign sat_val_ok = (value == trig_pkg::MAXW) || (value == trig_pkg::MINW)
		|| (value == '0);

	`TFU_NEVER(a_pop_empty, pop && qstat.empty)
	`TFU_NEVER(a_full_empty, qstat.full && qstat.empty)
	`TFU_IMPLY(a_sat_value, m_tvalid && m_tuser[0], sat_val_ok)

endmodule

@@ bench/trig_checker.sv @@
// scoreboard for the trig function unit: watches both stream channels,
// predicts each result and compares it with what comes out
// depends on trig_pkg for the kind codes and on the port widths of trig_function_unit
module trig_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // angle
	input  logic [2:0]  s_tuser,  // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // value
	input  logic [0:0]  m_tuser,  // saturated
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE_Q30   = 64'sd1 << 30;
	localparam longint PI_Q30    = 64'sd3373259426;
	localparam longint HPI_Q30   = 64'sd1686629713;
	localparam longint TWOPI_Q30 = 64'sd6746518852;
	localparam logic [63:0] TWOPI_Q60 = 64'h6487ED5110B4611A;
	localparam longint MAX_W = 64'sd2147483647;
	localparam longint MIN_W = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} trig_res_t;

	trig_res_t want_q[$];

	// divide by 2^s rounding to nearest, ties away from zero
	function automatic longint round_shift(longint v, int s);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		m = ((m >> (s - 1)) + 1) >> 1;
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_shift(a * b, 30);
	endfunction

	function automatic longint qdiv(longint a, longint b);
		return (a * ONE_Q30) / b;
	endfunction

	// fold into [-pi/2, pi/2] then odd minimax polynomial
	function automatic longint sine_poly(longint x);
		longint c [5];
		longint x2, acc;
		c = '{1073741818, -178956863, 8947518, -212681, 2794};
		x = x % TWOPI_Q30;
		if (PI_Q30 - x < x) x = PI_Q30 - x;
		if (-PI_Q30 - x > x) x = -PI_Q30 - x;
		if (PI_Q30 - x < x) x = PI_Q30 - x;
		x2 = qmul(x, x);
		acc = c[4];
		for (int i = 3; i >= 0; i--)
			acc = c[i] + qmul(acc, x2);
		return qmul(x, acc);
	endfunction

	function automatic trig_res_t trig_eval(logic [2:0] kind, logic [31:0] angle);
		trig_res_t r;
		longint a, twopi, r30, s, c, q, t, v;
		logic sat, fixed;
		sat = 1'b0;
		fixed = 1'b0;
		q = 0;
		v = 0;
		twopi = longint'(((TWOPI_Q60 >> 35) + 64'd1) >> 1);
		a = longint'($signed(angle)) % twopi;
		r30 = a * 64;
		s = sine_poly(r30);
		c = sine_poly(HPI_Q30 - r30);
		case (kind)
			trig_pkg::K_SIN: q = s;
			trig_pkg::K_COS: q = c;
			trig_pkg::K_TAN: begin
				if (c == 0) begin
					v = (s < 0) ? MIN_W : MAX_W; sat = 1; fixed = 1;
				end else q = qdiv(s, c);
			end
			trig_pkg::K_SEC: begin
				if (c == 0) begin
					v = MAX_W; sat = 1; fixed = 1;
				end else q = qdiv(ONE_Q30, c);
			end
			trig_pkg::K_CSC: begin
				if (s == 0) begin
					v = MAX_W; sat = 1; fixed = 1;
				end else q = qdiv(ONE_Q30, s);
			end
			trig_pkg::K_COT: begin
				if (c == 0) begin
					v = 0; sat = 1; fixed = 1;
				end else begin
					t = qdiv(s, c);
					if (t == 0) begin
						v = MAX_W; sat = 1; fixed = 1;
					end else q = qdiv(ONE_Q30, t);
				end
			end
			default: begin
				v = 0; fixed = 1;
			end
		endcase
		if (!fixed) begin
			v = round_shift(q, 6);
			if (v > MAX_W) begin v = MAX_W; sat = 1; end
			if (v < MIN_W) begin v = MIN_W; sat = 1; end
		end
		r.value = v[31:0];
		r.sat = sat;
		return r;
	endfunction

	initial errors = 0;
	assign pending = want_q.size();

	always @(posedge clk) begin
		trig_res_t w;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				want_q.push_back(trig_eval(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result beat: value %h sat %b", m_tdata, m_tuser);
					errors++;
				end else begin
					w = want_q.pop_front();
					if (m_tdata !== w.value || m_tuser[0] !== w.sat) begin
						if (errors < 10)
							$display("mismatch: value exp %h got %h, sat exp %b got %b",
								w.value, m_tdata, w.sat, m_tuser);
						errors++;
					end
				end
			end
		end
	end

endmodule

@@ bench/tb.sv @@
// top of the trig function unit bench: clock, reset, stimulus and verdict
// depends on trig_function_unit, trig_pkg and trig_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PI_Q24 = 26353589;
	localparam int PI_Q24      = 52707179;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	int          errors, pending;
	int          idle_pct = 0;
	int          stall_pct = 0;

	trig_function_unit uut (.*);

	trig_checker chk (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_angle(logic [2:0] kind, logic [31:0] angle);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= angle;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(3))
			0: return $urandom;
			// near a multiple of pi/2, where folding and poles sit
			1: return HALF_PI_Q24 * $signed($urandom_range(40) - 20)
				+ $signed($urandom_range(64) - 32);
			default: return $signed($urandom_range(32'd400000000)) - 200000000;
		endcase
	endfunction

	initial begin
		int dir [$];
		dir = '{0, 1, -1, 32'h7fffffff, 32'h80000000, HALF_PI_Q24, -HALF_PI_Q24,
			PI_Q24, -PI_Q24, 2 * PI_Q24, 105414357, -105414357, 3 * HALF_PI_Q24};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i])
			send_angle(trig_pkg::kind_t'(i % 6), dir[i]);
		for (int k = 0; k < 8; k++)
			send_angle(k[2:0], (k < 6) ? dir[k + 3] : 32'h0123_4567);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 20 : 54) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 20 : 54) : 0;
			for (int n = 0; n < 100; n++)
				send_angle(($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
					: 3'($urandom_range(5)), rand_angle());
			drain();
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** trig_function_unit: PASSED **");
		else
			$display("** trig_function_unit: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** trig_function_unit: FAILED **");
		$finish;
	end

endmodule
